// ===== rtl/mor_pkg.sv =====
// ----------------------------------------------------------------------------
// mor_pkg
// types and constants shared by the monochrome oled row flush block
// ----------------------------------------------------------------------------
package mor_pkg;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // byte kinds on the result channel
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_ARG  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // command ids
    localparam logic [2:0] CMD_X_START    = 3'd0;
    localparam logic [2:0] CMD_X_END      = 3'd1;
    localparam logic [2:0] CMD_Y_START    = 3'd2;
    localparam logic [2:0] CMD_Y_END      = 3'd3;
    localparam logic [2:0] CMD_DATA_WRITE = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_NATIVE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_NATIVE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_VIEW_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_VIEW_OFFSET_Y = 2'd3;

    // address limits and packing
    localparam logic [7:0] X_ADDR_LIMIT = 8'(128 >> 3);
    localparam logic [7:0] Y_ADDR_LIMIT = 8'd39;
    localparam int         PIX_PER_BYTE = 8;

    typedef struct packed {
        logic       operation;
        logic [9:0] store_address;
        logic [7:0] store_data;
        logic [6:0] rect_left;
        logic [6:0] rect_right;
        logic [6:0] rect_top;
        logic [6:0] rect_bottom;
        logic [6:0] row_index;
        logic [1:0] rotation;
    } item_t;

    typedef struct packed {
        logic [1:0] byte_kind;
        logic [2:0] command_id;
        logic [7:0] byte_value;
        logic       last_of_row;
    } result_t;

    typedef struct packed {
        logic [7:0] native_width;
        logic [7:0] native_height;
        logic [6:0] view_offset_x;
        logic [5:0] view_offset_y;
    } cfg_t;

    // everything a flush needs, worked out when the item is taken
    typedef struct packed {
        logic        skip;
        logic        turned;
        logic [3:0]  last_idx;
        logic [7:0]  x_start;
        logic [7:0]  x_end;
        logic [7:0]  y_addr;
        logic [15:0] ptr_start;
    } plan_t;

endpackage

// ===== rtl/mor_ram.sv =====
// ----------------------------------------------------------------------------
// mor_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mor_plan.sv =====
// ----------------------------------------------------------------------------
// mor_plan
// decodes a flush item into column span, box address arguments and the
// starting frame store pointer
// ----------------------------------------------------------------------------
module mor_plan #(
    parameter int MAX_ROW_BYTES = 16
) (
    input  mor_pkg::item_t item,
    input  mor_pkg::cfg_t  cfg,
    output mor_pkg::plan_t plan
);

    logic        turned;
    logic [3:0]  cs;
    logic [3:0]  ce;
    logic [6:0]  rs;
    logic [6:0]  re;
    logic [3:0]  span;
    logic [6:0]  yrow;
    logic [7:0]  ysum;
    logic [3:0]  xoff;
    logic [4:0]  xs_sum;
    logic [4:0]  xe_sum;
    logic [7:0]  w;
    logic [6:0]  mul_a;
    logic [7:0]  mul_b;
    logic [14:0] prod;
    logic [6:0]  add_term;

    always_comb
    begin
        turned = item.rotation[0];
        if (turned)
        begin
            cs = item.rect_top[6:3];
            ce = item.rect_bottom[6:3];
            rs = item.rect_left;
            re = item.rect_right;
        end
        else
        begin
            cs = item.rect_left[6:3];
            ce = item.rect_right[6:3];
            rs = item.rect_top;
            re = item.rect_bottom;
        end

        plan.skip   = (ce < cs) || (item.row_index < rs) || (item.row_index > re);
        plan.turned = turned;

        span = ce - cs;
        plan.last_idx = (span > 4'(MAX_ROW_BYTES - 1)) ? 4'(MAX_ROW_BYTES - 1) : span;

        // y mirrored against the bottom row of the range when rotation bit 1 is set
        yrow = item.rotation[1] ? (re - item.row_index) : item.row_index;
        ysum = {1'b0, yrow} + {2'b00, cfg.view_offset_y};
        plan.y_addr = (ysum > mor_pkg::Y_ADDR_LIMIT) ? mor_pkg::Y_ADDR_LIMIT : ysum;

        xoff   = cfg.view_offset_x[6:3];
        xs_sum = {1'b0, cs} + {1'b0, xoff};
        xe_sum = {1'b0, ce} + {1'b0, xoff};
        w      = {3'b000, cfg.native_width[7:3]} - 8'd1;
        if (turned)
        begin
            plan.x_start = (w >= {3'b000, xe_sum}) ? (w - {3'b000, xe_sum}) : 8'd0;
            plan.x_end   = (w >= {3'b000, xs_sum}) ? (w - {3'b000, xs_sum}) : 8'd0;
        end
        else
        begin
            plan.x_start = ({3'b000, xs_sum} > mor_pkg::X_ADDR_LIMIT) ?
                           mor_pkg::X_ADDR_LIMIT : {3'b000, xs_sum};
            plan.x_end   = ({3'b000, xe_sum} > mor_pkg::X_ADDR_LIMIT) ?
                           mor_pkg::X_ADDR_LIMIT : {3'b000, xe_sum};
        end

        // turned: pixel index of the first bit, else byte index of the first column
        if (turned)
        begin
            mul_a    = {cs, 3'b000};
            mul_b    = cfg.native_height;
            add_term = item.row_index;
        end
        else
        begin
            mul_a    = item.row_index;
            mul_b    = {3'b000, cfg.native_width[7:3]};
            add_term = {3'b000, cs};
        end
        prod = 15'(mul_a * mul_b);
        plan.ptr_start = {1'b0, prod} + {9'd0, add_term};
    end

endmodule

// ===== rtl/mono_oled_row_flush.sv =====
// ----------------------------------------------------------------------------
// mono_oled_row_flush
// 1 bit per pixel frame store with a row flusher that emits the box address
// commands, a data write command and the packed bytes of one row
//
//   channel   signals                               transfer when
//   item      item_valid, item_ready, item          item_valid & item_ready
//   result    result_valid, result_ready, result    result_valid & result_ready
//   config    cfg_valid, cfg_ready, cfg_index,      cfg_valid (ready always high)
//             cfg_data
//
// a store write is done on its item transfer. a flush sends 9 header bytes, then
// gathers each data byte from frame store reads, a whole byte unrotated or one bit
// per read at 90/270, one read per cycle through the single read port. after reset
// the store is cleared one byte a cycle with item_ready low. a stalled result holds
// the sequencer; the next item is taken once the last byte of a row sits in the
// output register.
// ----------------------------------------------------------------------------
module mono_oled_row_flush #(
    parameter int STORE_BYTES   = 640,
    parameter int MAX_ROW_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mor_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output mor_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int ABITS = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEADER,
        ST_FETCH,
        ST_DRAIN,
        ST_SEND
    } state_t;

    state_t           state_reg;
    mor_pkg::cfg_t    cfg_reg;
    mor_pkg::plan_t   plan;
    mor_pkg::result_t result_reg;
    logic             result_valid_reg;

    logic [ABITS-1:0] clr_reg;
    logic [3:0]       hdr_reg;
    logic [3:0]       col_reg;
    logic [2:0]       bit_reg;
    logic [15:0]      ptr_reg;
    logic             turned_reg;
    logic [3:0]       last_idx_reg;
    logic [7:0]       xs_reg;
    logic [7:0]       xe_reg;
    logic [7:0]       y_reg;

    logic             rd_valid_reg;
    logic [2:0]       rd_bit_reg;
    logic [2:0]       rd_sel_reg;
    logic             rd_ok_reg;
    logic [7:0]       acc_reg;
    logic [7:0]       acc_next;

    logic             can_load;
    logic             res_load;
    logic             item_xfer;
    logic [12:0]      baddr;
    logic [2:0]       bsel;
    logic             bok;
    logic [15:0]      step;
    logic             ram_we;
    logic [ABITS-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic [2:0]       hdr_id;
    logic [7:0]       hdr_value;
    logic             rd_bitv;
    logic [7:0]       acc_base;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_xfer    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign can_load     = !result_valid_reg || result_ready;
    assign res_load     = ((state_reg == ST_HEADER) || (state_reg == ST_SEND)) && can_load;

    mor_plan #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_plan (
        .item(item),
        .cfg (cfg_reg),
        .plan(plan)
    );

    // frame store pointer decode
    always_comb
    begin
        if (turned_reg)
        begin
            baddr = ptr_reg[15:3];
            bsel  = ptr_reg[2:0];
            step  = {8'd0, cfg_reg.native_height};
        end
        else
        begin
            baddr = ptr_reg[12:0];
            bsel  = 3'd0;
            step  = 16'd1;
        end
        bok = (baddr < 13'(STORE_BYTES));
    end

    // store write port: clearing pass or a write transfer
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_we    = item_xfer && (item.operation == mor_pkg::OP_WRITE) &&
                        ({3'b000, item.store_address} < 13'(STORE_BYTES));
            ram_waddr = ABITS'(item.store_address);
            ram_wdata = item.store_data;
        end
    end

    mor_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ABITS'(baddr)),
        .rdata(ram_rdata)
    );

    // bit gather
    always_comb
    begin
        rd_bitv  = rd_ok_reg && ram_rdata[rd_sel_reg];
        acc_base = (rd_bit_reg == 3'd0) ? 8'd0 : acc_reg;
        acc_next = acc_reg;
        if (rd_valid_reg)
        begin
            if (turned_reg)
            begin
                acc_next = acc_base | (8'(rd_bitv) << rd_bit_reg);
            end
            else
            begin
                acc_next = rd_ok_reg ? ram_rdata : 8'd0;
            end
        end
    end

    // header byte select
    always_comb
    begin
        hdr_id = 3'(hdr_reg >> 1);
        unique case (hdr_id)
            mor_pkg::CMD_X_START: hdr_value = xs_reg;
            mor_pkg::CMD_X_END:   hdr_value = xe_reg;
            default:              hdr_value = y_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
            hdr_reg          <= 4'd0;
            col_reg          <= 4'd0;
            bit_reg          <= 3'd0;
            turned_reg       <= 1'b0;
            last_idx_reg     <= 4'd0;
            cfg_reg.native_width  <= 8'd128;
            cfg_reg.native_height <= 8'd40;
            cfg_reg.view_offset_x <= 7'd0;
            cfg_reg.view_offset_y <= 6'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mor_pkg::REG_NATIVE_WIDTH:  cfg_reg.native_width  <= cfg_data;
                    mor_pkg::REG_NATIVE_HEIGHT: cfg_reg.native_height <= cfg_data;
                    mor_pkg::REG_VIEW_OFFSET_X: cfg_reg.view_offset_x <= cfg_data[6:0];
                    mor_pkg::REG_VIEW_OFFSET_Y: cfg_reg.view_offset_y <= cfg_data[5:0];
                    default: ;
                endcase
            end

            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            rd_valid_reg <= (state_reg == ST_FETCH);
            rd_bit_reg   <= bit_reg;
            rd_sel_reg   <= bsel;
            rd_ok_reg    <= bok;
            acc_reg      <= acc_next;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ABITS'(STORE_BYTES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item_xfer && (item.operation == mor_pkg::OP_FLUSH) && !plan.skip)
                    begin
                        turned_reg   <= plan.turned;
                        last_idx_reg <= plan.last_idx;
                        xs_reg       <= plan.x_start;
                        xe_reg       <= plan.x_end;
                        y_reg        <= plan.y_addr;
                        ptr_reg      <= plan.ptr_start;
                        hdr_reg      <= 4'd0;
                        col_reg      <= 4'd0;
                        bit_reg      <= 3'd0;
                        state_reg    <= ST_HEADER;
                    end
                end
                ST_HEADER:
                begin
                    if (can_load)
                    begin
                        result_reg.byte_kind   <= hdr_reg[0] ? mor_pkg::KIND_ARG :
                                                               mor_pkg::KIND_CMD;
                        result_reg.command_id  <= hdr_id;
                        result_reg.byte_value  <= hdr_reg[0] ? hdr_value : 8'd0;
                        result_reg.last_of_row <= 1'b0;
                        if (hdr_id == mor_pkg::CMD_DATA_WRITE)
                        begin
                            state_reg <= ST_FETCH;
                        end
                        else
                        begin
                            hdr_reg <= hdr_reg + 4'd1;
                        end
                    end
                end
                ST_FETCH:
                begin
                    ptr_reg <= ptr_reg + step;
                    if (!turned_reg || (bit_reg == 3'(mor_pkg::PIX_PER_BYTE - 1)))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        bit_reg <= bit_reg + 3'd1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (can_load)
                    begin
                        result_reg.byte_kind   <= mor_pkg::KIND_DATA;
                        result_reg.command_id  <= mor_pkg::CMD_DATA_WRITE;
                        result_reg.byte_value  <= acc_reg;
                        result_reg.last_of_row <= (col_reg == last_idx_reg);
                        if (col_reg == last_idx_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 4'd1;
                            bit_reg   <= 3'd0;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_mono_oled_row_flush.sv =====
// ----------------------------------------------------------------------------
// tb_mono_oled_row_flush
// self-checking bench for the monochrome oled row flusher: frame store writes
// and row flushes at all four rotations go in with random gaps, a local model
// of the store and the address math predicts every bus byte, and a monitor
// compares each result transfer against the oldest predicted byte
// ----------------------------------------------------------------------------
module tb_mono_oled_row_flush;

    localparam int STORE_BYTES   = 640;
    localparam int MAX_ROW_BYTES = 16;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SEGMENTS      = 5;
    localparam int SEGMENT_ITEMS = 38;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    mor_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    mor_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [7:0]       cfg_data;

    logic [7:0]       pixel_store [STORE_BYTES];
    mor_pkg::cfg_t    panel_cfg;
    mor_pkg::result_t pending_bytes [$];
    int               fail_count;
    int               cycle_count;
    int               stall_left;
    bit               quiet;
    mor_pkg::result_t want;

    mono_oled_row_flush #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    task automatic note_failure(input string text);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", text);
        end
    endtask

    function automatic logic [7:0] store_byte(input int addr);
        if (addr < 0 || addr >= STORE_BYTES)
        begin
            return 8'd0;
        end
        return pixel_store[addr];
    endfunction

    task automatic push_byte(input logic [1:0] kind, input logic [2:0] id,
                             input int value, input logic last);
        mor_pkg::result_t r;
        r.byte_kind   = kind;
        r.command_id  = id;
        r.byte_value  = value[7:0];
        r.last_of_row = last;
        pending_bytes.push_back(r);
    endtask

    // applies one accepted transfer to the local store and queues its bus bytes
    task automatic predict_row_bytes(input mor_pkg::item_t it);
        logic       turned;
        logic       inverted;
        int         cs, ce, rs, re, row, len, yrow;
        int         pw, ph, xoff, w, xs, xe, ya, pix;
        logic [7:0] fetched;
        logic [7:0] acc;
        logic [7:0] data_bytes [MAX_ROW_BYTES];
        if (it.operation == mor_pkg::OP_WRITE)
        begin
            if (int'(it.store_address) < STORE_BYTES)
            begin
                pixel_store[it.store_address] = it.store_data;
            end
            return;
        end
        turned   = it.rotation[0];
        inverted = it.rotation[1];
        row      = int'(it.row_index);
        if (!turned)
        begin
            cs = int'(it.rect_left) >> 3;
            ce = int'(it.rect_right) >> 3;
            rs = int'(it.rect_top);
            re = int'(it.rect_bottom);
        end
        else
        begin
            cs = int'(it.rect_top) >> 3;
            ce = int'(it.rect_bottom) >> 3;
            rs = int'(it.rect_left);
            re = int'(it.rect_right);
        end
        if (ce < cs || row < rs || row > re)
        begin
            return;
        end
        len = ce - cs + 1;
        if (len > MAX_ROW_BYTES)
        begin
            len = MAX_ROW_BYTES;
        end
        yrow = inverted ? re - row : row;
        pw   = int'(panel_cfg.native_width);
        ph   = int'(panel_cfg.native_height);
        xoff = int'(panel_cfg.view_offset_x) >> 3;
        for (int i = 0; i < len; i++)
        begin
            if (!turned)
            begin
                data_bytes[i] = store_byte(row * (pw >> 3) + cs + i);
            end
            else
            begin
                acc = 8'd0;
                for (int b = 0; b < mor_pkg::PIX_PER_BYTE; b++)
                begin
                    pix     = ((cs + i) * mor_pkg::PIX_PER_BYTE + b) * ph + row;
                    fetched = store_byte(pix >> 3);
                    acc[b]  = fetched[pix % 8];
                end
                data_bytes[i] = acc;
            end
        end
        if (!turned)
        begin
            xs = cs + xoff;
            xe = ce + xoff;
            if (xs > int'(mor_pkg::X_ADDR_LIMIT))
            begin
                xs = int'(mor_pkg::X_ADDR_LIMIT);
            end
            if (xe > int'(mor_pkg::X_ADDR_LIMIT))
            begin
                xe = int'(mor_pkg::X_ADDR_LIMIT);
            end
        end
        else
        begin
            w  = ((pw >> 3) - 1) & 255;
            xs = (w >= ce + xoff) ? w - ce - xoff : 0;
            xe = (w >= cs + xoff) ? w - cs - xoff : 0;
        end
        ya = yrow + int'(panel_cfg.view_offset_y);
        if (ya > int'(mor_pkg::Y_ADDR_LIMIT))
        begin
            ya = int'(mor_pkg::Y_ADDR_LIMIT);
        end
        push_byte(mor_pkg::KIND_CMD, mor_pkg::CMD_X_START, 0, 1'b0);
        push_byte(mor_pkg::KIND_ARG, mor_pkg::CMD_X_START, xs, 1'b0);
        push_byte(mor_pkg::KIND_CMD, mor_pkg::CMD_X_END, 0, 1'b0);
        push_byte(mor_pkg::KIND_ARG, mor_pkg::CMD_X_END, xe, 1'b0);
        push_byte(mor_pkg::KIND_CMD, mor_pkg::CMD_Y_START, 0, 1'b0);
        push_byte(mor_pkg::KIND_ARG, mor_pkg::CMD_Y_START, ya, 1'b0);
        push_byte(mor_pkg::KIND_CMD, mor_pkg::CMD_Y_END, 0, 1'b0);
        push_byte(mor_pkg::KIND_ARG, mor_pkg::CMD_Y_END, ya, 1'b0);
        push_byte(mor_pkg::KIND_CMD, mor_pkg::CMD_DATA_WRITE, 0, 1'b0);
        for (int i = 0; i < len; i++)
        begin
            push_byte(mor_pkg::KIND_DATA, mor_pkg::CMD_DATA_WRITE, int'(data_bytes[i]),
                      i + 1 == len);
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                note_failure($sformatf("unexpected result kind=%0d id=%0d value=%0d last=%0d",
                    result.byte_kind, result.command_id, result.byte_value,
                    result.last_of_row));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (result.byte_kind !== want.byte_kind
                    || result.command_id !== want.command_id
                    || result.byte_value !== want.byte_value
                    || result.last_of_row !== want.last_of_row)
                begin
                    note_failure($sformatf(
                        "mismatch kind/id/value/last exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.byte_kind, want.command_id, want.byte_value, want.last_of_row,
                        result.byte_kind, result.command_id, result.byte_value,
                        result.last_of_row));
                end
            end
        end
    end

    // result backpressure
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input mor_pkg::item_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_row_bytes(it);
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mor_pkg::REG_NATIVE_WIDTH:  panel_cfg.native_width  = value;
            mor_pkg::REG_NATIVE_HEIGHT: panel_cfg.native_height = value;
            mor_pkg::REG_VIEW_OFFSET_X: panel_cfg.view_offset_x = value[6:0];
            mor_pkg::REG_VIEW_OFFSET_Y: panel_cfg.view_offset_y = value[5:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_panel(input int pw, input int ph, input int ox, input int oy);
        wait_all_results();
        write_reg(mor_pkg::REG_NATIVE_WIDTH, pw[7:0]);
        write_reg(mor_pkg::REG_NATIVE_HEIGHT, ph[7:0]);
        write_reg(mor_pkg::REG_VIEW_OFFSET_X, ox[7:0]);
        write_reg(mor_pkg::REG_VIEW_OFFSET_Y, oy[7:0]);
    endtask

    function automatic mor_pkg::item_t random_base();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(mor_pkg::item_t)-1:0];
    endfunction

    function automatic mor_pkg::item_t write_item(input int addr, input int data);
        mor_pkg::item_t it;
        it               = random_base();
        it.operation     = mor_pkg::OP_WRITE;
        it.store_address = addr[9:0];
        it.store_data    = data[7:0];
        return it;
    endfunction

    function automatic mor_pkg::item_t flush_item(input int rot, input int l, input int r,
                                                  input int t, input int b, input int row);
        mor_pkg::item_t it;
        it             = random_base();
        it.operation   = mor_pkg::OP_FLUSH;
        it.rotation    = rot[1:0];
        it.rect_left   = l[6:0];
        it.rect_right  = r[6:0];
        it.rect_top    = t[6:0];
        it.rect_bottom = b[6:0];
        it.row_index   = row[6:0];
        return it;
    endfunction

    // flush whose row lies inside the rectangle, mostly narrow
    function automatic mor_pkg::item_t random_flush();
        int rot, cs, ce, span, lo, hi, rs, re, row;
        rot  = $urandom_range(0, 3);
        cs   = $urandom_range(0, 15);
        span = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 15);
        ce   = (cs + span > 15) ? 15 : cs + span;
        lo   = cs * 8 + $urandom_range(0, 7);
        hi   = ce * 8 + $urandom_range(0, 7);
        rs   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30);
        re   = rs + $urandom_range(0, 12);
        if (re > 127)
        begin
            re = 127;
        end
        row = $urandom_range(rs, re);
        if (rot % 2 == 0)
        begin
            return flush_item(rot, lo, hi, rs, re, row);
        end
        return flush_item(rot, rs, re, lo, hi, row);
    endfunction

    task automatic test_reset_defaults();
        quiet = 1'b1;
        send_item(write_item(0, 8'hA5));
        send_item(write_item(15, 8'hFF));
        send_item(write_item(16, 8'h01));
        send_item(write_item(639, 8'h80));
        send_item(flush_item(0, 0, 127, 0, 0, 0));
        send_item(flush_item(1, 0, 127, 0, 127, 0));
        wait_all_results();
        quiet = 1'b0;
    endtask

    task automatic test_row_window();
        send_item(write_item(640, 8'h5A));
        send_item(write_item(1023, 8'hC3));
        send_item(flush_item(0, 0, 31, 10, 20, 9));
        send_item(flush_item(0, 0, 31, 10, 20, 21));
        send_item(flush_item(1, 30, 10, 0, 15, 20));
        send_item(flush_item(0, 64, 8, 0, 5, 2));
        send_item(flush_item(2, 8, 40, 3, 10, 4));
        send_item(flush_item(3, 5, 60, 8, 127, 60));
        wait_all_results();
    endtask

    task automatic test_addr_clamps();
        set_panel(128, 40, 127, 63);
        send_item(flush_item(0, 8, 127, 20, 35, 30));
        send_item(flush_item(1, 0, 100, 0, 127, 100));
        set_panel(8, 1, 0, 0);
        send_item(flush_item(3, 0, 3, 0, 7, 2));
        set_panel(128, 128, 0, 39);
        send_item(flush_item(1, 0, 127, 0, 127, 127));
        wait_all_results();
    endtask

    task automatic test_small_panel();
        set_panel(0, 255, 5, 0);
        send_item(flush_item(0, 0, 23, 0, 4, 3));
        send_item(flush_item(1, 0, 4, 16, 40, 2));
        set_panel(255, 255, 127, 63);
        send_item(flush_item(2, 0, 127, 0, 2, 1));
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int pw, ph, ox, oy, sent, r;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            pw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                               $urandom_range(1, 16) * 8;
            ph = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                               $urandom_range(1, 128);
            ox = $urandom_range(0, 127);
            oy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 39);
            set_panel(pw, ph, ox, oy);
            quiet = (seg == 2);
            sent  = 0;
            while (sent < SEGMENT_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_item(write_item($urandom_range(640, 1023), $urandom_range(0, 255)));
                    end
                    else
                    begin
                        send_item(write_item($urandom_range(0, 639), $urandom_range(0, 255)));
                    end
                    sent++;
                end
                else if (r < 85)
                begin
                    send_item(random_flush());
                    sent++;
                end
                else
                begin
                    send_item(flush_item($urandom_range(0, 3), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127)));
                    sent++;
                end
            end
            quiet = 1'b0;
        end
        wait_all_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        cycle_count = 0;
        stall_left  = 0;
        quiet       = 1'b0;
        panel_cfg.native_width  = 8'd128;
        panel_cfg.native_height = 8'd40;
        panel_cfg.view_offset_x = 7'd0;
        panel_cfg.view_offset_y = 6'd0;
        for (int a = 0; a < STORE_BYTES; a++)
        begin
            pixel_store[a] = 8'd0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_row_window();
        test_addr_clamps();
        test_small_panel();
        test_random_traffic();

        if (fail_count == 0 && pending_bytes.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mor_pkg.sv
rtl/mor_ram.sv
rtl/mor_plan.sv
rtl/mono_oled_row_flush.sv
tb/tb_mono_oled_row_flush.sv
